// ===== sv/scba_pkg.sv =====
`timescale 1ns / 1ps

package scba_pkg;

    localparam int HANDLE_COUNT = 8192;
    localparam int CLASS_COUNT  = 7;
    localparam int HANDLE_W     = 13;
    localparam int LINK_W       = 14;
    localparam int CLASS_W      = 3;
    localparam int BYTES_W      = 24;
    localparam int KB_W         = 24;
    localparam int STATUS_W     = 3;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(HANDLE_COUNT);

    localparam logic [STATUS_W-1:0] ST_POOL      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd5;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [KB_W-1:0] LIMIT_RESET = 24'd5242880;

    localparam int unsigned CLASS_KB [CLASS_COUNT] = '{4, 16, 64, 256, 1024, 4096, 8192};
    localparam int unsigned CLASS_PREALLOC [CLASS_COUNT] = '{5000, 1000, 500, 200, 50, 20, 10};

    function automatic int unsigned class_start(input int c);
        int unsigned acc;
        acc = 0;
        for (int k = 0; k < CLASS_COUNT; k++) begin
            if (k < c) begin
                acc += CLASS_PREALLOC[k];
            end
        end
        return acc;
    endfunction

    function automatic logic [LINK_W-1:0] head_reset(input int c);
        if (CLASS_PREALLOC[c] == 0 || class_start(c) >= HANDLE_COUNT) begin
            return LINK_NULL;
        end
        return LINK_W'(class_start(c));
    endfunction

    function automatic logic [LINK_W-1:0] fresh_reset();
        int unsigned total;
        total = class_start(CLASS_COUNT);
        return (total < HANDLE_COUNT) ? LINK_W'(total) : LINK_NULL;
    endfunction

    function automatic logic [KB_W-1:0] used_reset();
        int unsigned kb;
        kb = 0;
        for (int k = 0; k < CLASS_COUNT; k++) begin
            kb += CLASS_PREALLOC[k] * CLASS_KB[k];
        end
        return KB_W'(kb);
    endfunction

    function automatic logic [LINK_W-1:0] link_reset(input logic [HANDLE_W-1:0] h);
        int unsigned acc;
        logic        last;
        acc  = 0;
        last = 1'b0;
        for (int k = 0; k < CLASS_COUNT; k++) begin
            acc += CLASS_PREALLOC[k];
            if (CLASS_PREALLOC[k] != 0 && 32'(h) == acc - 1) begin
                last = 1'b1;
            end
        end
        if (last || 32'(h) >= acc) begin
            return LINK_NULL;
        end
        return LINK_W'(h) + LINK_W'(1);
    endfunction

    function automatic logic [BYTES_W:0] class_bytes(input int c);
        return (BYTES_W + 1)'(CLASS_KB[c]) << 10;
    endfunction

endpackage

// ===== sv/scba_ram.sv =====
`timescale 1ns / 1ps

module scba_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/size_class_buffer_allocator.sv =====
`timescale 1ns / 1ps
// Size-class buffer allocator with seven LIFO free lists of buffer handles.
// Input beats arrive on the s_axis channel: tuser is the operation (allocate or
// release), tdata carries the request size in bytes, the handle and its class.
// Each input beat produces exactly one result beat on the m_axis channel with
// the granted handle, the chosen class and a status code in tuser.
// On accept the head's next link is read from the link memory; in the execute
// state that follows, the head is updated, the link memory written and the
// output register loaded. One item is in work at a time: a new item is not
// accepted until the last one has left the execute state.
// When the receiver stalls, the finished result waits in the output register;
// one more item is accepted and then holds in the execute state until the
// output register frees up.
// After reset all 8192 link memory entries are rebuilt in one pass, one entry a
// cycle; tready stays low during that pass. The limit register may be written
// at any time through i_cfg_we and i_cfg_wdata, and resets to 5242880 KB.
module size_class_buffer_allocator
    import scba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // request_bytes[23:0], buffer_handle[36:24], buffer_class[39:37]
    input  logic [39:0] i_s_axis_tdata,
    // operation[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // granted_handle[12:0], granted_class[15:13]
    output logic [15:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]  o_m_axis_tuser
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                r_state;
    logic                r_init;
    logic [HANDLE_W-1:0] r_init_cnt;
    logic [KB_W-1:0]     r_limit;
    logic [LINK_W-1:0]   r_heads [CLASS_COUNT];
    logic [LINK_W-1:0]   r_fresh;
    logic [KB_W-1:0]     r_used;

    logic                r_op;
    logic                r_too_large;
    logic [CLASS_W-1:0]  r_cls;
    logic [HANDLE_W-1:0] r_handle;

    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [CLASS_W-1:0]  r_out_class;
    logic [STATUS_W-1:0] r_out_status;

    logic [BYTES_W-1:0]  in_bytes;
    logic [HANDLE_W-1:0] in_handle;
    logic [CLASS_W-1:0]  in_class;
    logic                accept;
    logic                fits_any;
    logic [CLASS_W-1:0]  sel_class;
    logic [LINK_W-1:0]   sel_head;

    logic                we;
    logic [HANDLE_W-1:0] waddr;
    logic [LINK_W-1:0]   wdata;
    logic [LINK_W-1:0]   rdata;

    logic                can_finish;
    logic                finish;
    logic [LINK_W-1:0]   cur_head;
    logic [KB_W:0]       kb_sum;
    logic [KB_W-1:0]     cls_kb;
    logic                rel_ok;

    logic [HANDLE_W-1:0] res_handle;
    logic [CLASS_W-1:0]  res_class;
    logic [STATUS_W-1:0] res_status;
    logic                do_pop;
    logic                do_fresh;

    assign in_bytes  = i_s_axis_tdata[23:0];
    assign in_handle = i_s_axis_tdata[36:24];
    assign in_class  = i_s_axis_tdata[39:37];

    assign o_s_axis_tready = !r_init && (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        fits_any  = 1'b0;
        sel_class = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if ({1'b0, in_bytes} <= class_bytes(c)) begin
                fits_any  = 1'b1;
                sel_class = CLASS_W'(c);
            end
        end
    end

    assign sel_head = r_heads[sel_class];

    assign can_finish = !r_out_valid || i_m_axis_tready;
    assign finish     = (r_state == S_EXEC) && can_finish;
    assign cur_head   = r_heads[r_cls];
    assign rel_ok     = (32'(r_cls) < CLASS_COUNT);

    always_comb begin
        cls_kb = '0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            if (r_cls == CLASS_W'(c)) begin
                cls_kb = KB_W'(CLASS_KB[c]);
            end
        end
    end

    assign kb_sum = {1'b0, r_used} + {1'b0, cls_kb};

    always_comb begin
        res_handle = '0;
        res_class  = '0;
        res_status = ST_RELEASED;
        do_pop     = 1'b0;
        do_fresh   = 1'b0;
        if (r_op == OP_ALLOC) begin
            if (r_too_large) begin
                res_status = ST_TOO_LARGE;
            end else begin
                res_class = r_cls;
                priority if (!cur_head[LINK_W-1]) begin
                    res_handle = cur_head[HANDLE_W-1:0];
                    res_status = ST_POOL;
                    do_pop     = 1'b1;
                end else if (kb_sum >= {1'b0, r_limit}) begin
                    res_status = ST_LIMIT;
                end else if (r_fresh[LINK_W-1]) begin
                    res_status = ST_EXHAUSTED;
                end else begin
                    res_handle = r_fresh[HANDLE_W-1:0];
                    res_status = ST_FRESH;
                    do_fresh   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_init_cnt;
        wdata = link_reset(r_init_cnt);
        if (r_init) begin
            we = 1'b1;
        end else if (finish) begin
            if (r_op == OP_RELEASE) begin
                we    = rel_ok;
                waddr = r_handle;
                wdata = cur_head;
            end else if (do_pop) begin
                we    = 1'b1;
                waddr = cur_head[HANDLE_W-1:0];
                wdata = LINK_NULL;
            end else if (do_fresh) begin
                we    = 1'b1;
                waddr = r_fresh[HANDLE_W-1:0];
                wdata = LINK_NULL;
            end
        end
    end

    scba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (HANDLE_COUNT)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (sel_head[HANDLE_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b1;
            r_init_cnt  <= '0;
            r_limit     <= LIMIT_RESET;
            r_fresh     <= fresh_reset();
            r_used      <= used_reset();
            r_out_valid <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_heads[c] <= head_reset(c);
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_init) begin
                r_init_cnt <= r_init_cnt + HANDLE_W'(1);
                if (r_init_cnt == HANDLE_W'(HANDLE_COUNT - 1)) begin
                    r_init <= 1'b0;
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (finish) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (r_op == OP_RELEASE) begin
                            if (rel_ok) begin
                                r_heads[r_cls] <= {1'b0, r_handle};
                            end
                        end else if (do_pop) begin
                            r_heads[r_cls] <= rdata;
                        end else if (do_fresh) begin
                            r_fresh <= r_fresh + LINK_W'(1);
                            r_used  <= kb_sum[KB_W-1:0];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_s_axis_tuser;
            r_too_large <= !fits_any;
            r_cls       <= (i_s_axis_tuser == OP_RELEASE) ? in_class : sel_class;
            r_handle    <= in_handle;
        end
        if (finish) begin
            r_out_handle <= res_handle;
            r_out_class  <= res_class;
            r_out_status <= res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_class, r_out_handle};
    assign o_m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= LINK_NULL)
        else $error("fresh handle counter passed the handle count");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_s_axis_tready)
        else $error("input accepted during link memory rebuild");

    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(accept || r_state == S_EXEC))
        else $error("execute cycle without an accepted beat");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_m_axis_tvalid)
        else $error("finished item did not produce a result beat");
`endif

endmodule

// ===== tb/size_class_buffer_allocator_tb.sv =====
`timescale 1ns / 1ps

module size_class_buffer_allocator_tb;
    import scba_pkg::*;

    localparam int QUIET_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [KB_W-1:0] LIMIT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic                  op;
        logic [BYTES_W-1:0]    bytes;
        logic [HANDLE_W-1:0]   handle;
        logic [CLASS_W-1:0]    cls;
    } request_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [CLASS_W-1:0]    cls;
        logic [STATUS_W-1:0]   status;
    } grant_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        grant_t   want;
    } row_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [CLASS_W-1:0]  cls;
    } held_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [23:0]         i_cfg_wdata = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [39:0]         i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [15:0]         o_m_axis_tdata;
    logic [2:0]          o_m_axis_tuser;

    // Predictor state of the free lists.
    logic [LINK_W-1:0]   free_head [CLASS_COUNT];
    logic [LINK_W-1:0]   free_link [HANDLE_COUNT];
    logic [LINK_W-1:0]   fresh_next;
    logic [KB_W-1:0]     used_kb;
    logic [KB_W-1:0]     limit_kb;

    grant_t              pending_grants [$];
    held_t               held_bufs [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  tx_pct = 0;
    int                  rx_pct = 0;
    bit                  hold_ask = 1'b0;

    row_t directed_rows [0:21] = '{
        '{'{OP_ALLOC,   24'd0,        13'd0,    3'd0}, 1'b1, '{13'd0,    3'd0, ST_POOL}},
        '{'{OP_ALLOC,   24'd4096,     13'd0,    3'd0}, 1'b1, '{13'd1,    3'd0, ST_POOL}},
        '{'{OP_ALLOC,   24'd4097,     13'd0,    3'd0}, 1'b1, '{13'd5000, 3'd1, ST_POOL}},
        '{'{OP_ALLOC,   24'd16384,    13'd0,    3'd0}, 1'b1, '{13'd5001, 3'd1, ST_POOL}},
        '{'{OP_ALLOC,   24'd16385,    13'd0,    3'd0}, 1'b1, '{13'd6000, 3'd2, ST_POOL}},
        '{'{OP_ALLOC,   24'd65537,    13'd0,    3'd0}, 1'b1, '{13'd6500, 3'd3, ST_POOL}},
        '{'{OP_ALLOC,   24'd262145,   13'd0,    3'd0}, 1'b1, '{13'd6700, 3'd4, ST_POOL}},
        '{'{OP_ALLOC,   24'd1048577,  13'd0,    3'd0}, 1'b1, '{13'd6750, 3'd5, ST_POOL}},
        '{'{OP_ALLOC,   24'd8388608,  13'd0,    3'd0}, 1'b1, '{13'd6770, 3'd6, ST_POOL}},
        '{'{OP_ALLOC,   24'd8388609,  13'd0,    3'd0}, 1'b1, '{13'd0, 3'd0, ST_TOO_LARGE}},
        '{'{OP_ALLOC,   24'd16777215, 13'd8191, 3'd7}, 1'b1, '{13'd0, 3'd0, ST_TOO_LARGE}},
        '{'{OP_RELEASE, 24'd0,        13'd1,    3'd0}, 1'b1, '{13'd0, 3'd0, ST_RELEASED}},
        '{'{OP_ALLOC,   24'd100,      13'd0,    3'd0}, 1'b1, '{13'd1,    3'd0, ST_POOL}},
        '{'{OP_RELEASE, 24'hFFFFFF,   13'd8191, 3'd7}, 1'b1, '{13'd0, 3'd0, ST_RELEASED}},
        '{'{OP_RELEASE, 24'd0,        13'd8191, 3'd6}, 1'b1, '{13'd0, 3'd0, ST_RELEASED}},
        '{'{OP_ALLOC,   24'd8388608,  13'd0,    3'd0}, 1'b1, '{13'd8191, 3'd6, ST_POOL}},
        '{'{OP_RELEASE, 24'd0,        13'd6770, 3'd6}, 1'b1, '{13'd0, 3'd0, ST_RELEASED}},
        '{'{OP_RELEASE, 24'd0,        13'd6770, 3'd6}, 1'b1, '{13'd0, 3'd0, ST_RELEASED}},
        '{'{OP_ALLOC,   24'd4194305,  13'd0,    3'd0}, 1'b0, '{13'd0, 3'd0, ST_POOL}},
        '{'{OP_ALLOC,   24'd8388608,  13'd0,    3'd0}, 1'b0, '{13'd0, 3'd0, ST_POOL}},
        '{'{OP_ALLOC,   24'd8388608,  13'd0,    3'd0}, 1'b0, '{13'd0, 3'd0, ST_POOL}},
        '{'{OP_ALLOC,   24'd1048576,  13'd0,    3'd0}, 1'b0, '{13'd0, 3'd0, ST_POOL}}
    };

    size_class_buffer_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    task automatic reset_free_lists();
        int unsigned start;
        int unsigned kb;
        int unsigned n;
        start = 0;
        kb = 0;
        for (int h = 0; h < HANDLE_COUNT; h++) begin
            free_link[h] = LINK_NULL;
        end
        for (int c = 0; c < CLASS_COUNT; c++) begin
            n = CLASS_PREALLOC[c];
            free_head[c] = (n != 0 && start < HANDLE_COUNT) ? LINK_W'(start) : LINK_NULL;
            for (int unsigned i = 0; i < n; i++) begin
                if (start + i < HANDLE_COUNT) begin
                    free_link[HANDLE_W'(start + i)] =
                        (i + 1 < n) ? LINK_W'(start + i + 1) : LINK_NULL;
                end
            end
            start += n;
            kb += n * CLASS_KB[c];
        end
        fresh_next = (start < HANDLE_COUNT) ? LINK_W'(start) : LINK_NULL;
        used_kb = KB_W'(kb);
        limit_kb = LIMIT_RESET;
    endtask

    task automatic predict_grant(input request_t rq, output grant_t g);
        int                sel;
        logic [LINK_W-1:0] top;
        g = '{handle: '0, cls: '0, status: ST_RELEASED};
        if (rq.op == OP_RELEASE) begin
            if (rq.cls < CLASS_COUNT) begin
                free_link[rq.handle] = free_head[rq.cls];
                free_head[rq.cls] = LINK_W'(rq.handle);
            end
        end else begin
            sel = CLASS_COUNT;
            for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
                if (32'(rq.bytes) <= CLASS_KB[c] * 1024) begin
                    sel = c;
                end
            end
            if (sel == CLASS_COUNT) begin
                g.status = ST_TOO_LARGE;
            end else begin
                g.cls = CLASS_W'(sel);
                top = free_head[CLASS_W'(sel)];
                if (top < HANDLE_COUNT) begin
                    free_head[CLASS_W'(sel)] = free_link[top[HANDLE_W-1:0]];
                    free_link[top[HANDLE_W-1:0]] = LINK_NULL;
                    g.handle = top[HANDLE_W-1:0];
                    g.status = ST_POOL;
                end else if (32'(used_kb) + CLASS_KB[sel] >= 32'(limit_kb)) begin
                    g.status = ST_LIMIT;
                end else if (fresh_next >= HANDLE_COUNT) begin
                    g.status = ST_EXHAUSTED;
                end else begin
                    g.handle = fresh_next[HANDLE_W-1:0];
                    free_link[fresh_next[HANDLE_W-1:0]] = LINK_NULL;
                    fresh_next = fresh_next + 1'b1;
                    used_kb = used_kb + KB_W'(CLASS_KB[sel]);
                    g.status = ST_FRESH;
                end
            end
        end
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic offer(input request_t rq, input logic typed, input grant_t want);
        grant_t g;
        while ($urandom_range(99) < tx_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {rq.cls, rq.handle, rq.bytes};
        i_s_axis_tuser <= rq.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_grant(rq, g);
        if (g.status == ST_POOL || g.status == ST_FRESH) begin
            held_bufs.push_back('{handle: g.handle, cls: g.cls});
        end
        pending_grants.push_back(typed ? want : g);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0);
    endtask

    task automatic make_request(input int heavy_pct, output request_t rq);
        int k;
        int c;
        int idx;
        rq.op = OP_ALLOC;
        rq.bytes = BYTES_W'($urandom);
        rq.handle = HANDLE_W'($urandom);
        rq.cls = CLASS_W'($urandom);
        k = $urandom_range(99);
        if (k < heavy_pct) begin
            rq.bytes = BYTES_W'($urandom_range(8388608, 4194305));
        end else begin
            k = $urandom_range(99);
            if (k >= 60 && k < 90 && held_bufs.size() == 0) begin
                k = 0;
            end
            if (k < 50) begin
                c = $urandom_range(CLASS_COUNT - 1);
                rq.bytes = BYTES_W'($urandom_range(CLASS_KB[c] * 1024,
                                   (c == 0) ? 0 : CLASS_KB[c - 1] * 1024 + 1));
            end else if (k < 55) begin
                rq.bytes = BYTES_W'($urandom_range(16777215, 8388609));
            end else if (k < 60) begin
                // Keep the random size from the first draw.
            end else if (k < 90) begin
                idx = $urandom_range(held_bufs.size() - 1);
                rq.op = OP_RELEASE;
                rq.handle = held_bufs[idx].handle;
                rq.cls = held_bufs[idx].cls;
                held_bufs.delete(idx);
            end else begin
                rq.op = OP_RELEASE;
            end
        end
    endtask

    task automatic run_phase(input logic [KB_W-1:0] limit, input int tx, input int rx,
                             input int count, input int heavy_pct, input bit exhaust,
                             input bit long_hold, input int pause_at);
        request_t rq;
        int       done;
        int       tail;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_kb = limit;
        tx_pct = tx;
        rx_pct = rx;
        hold_ask = long_hold;
        done = 0;
        tail = 0;
        while (tail < count && done < 4000) begin
            make_request(heavy_pct, rq);
            offer(rq, 1'b0, '0);
            done++;
            if (!exhaust || fresh_next >= HANDLE_COUNT) begin
                tail++;
            end
            if (done == pause_at) begin
                drain();
            end
        end
    endtask

    // Result side: checks every taken beat, then picks the next tready.
    initial begin
        grant_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_grants.size() == 0) begin
                    $display("%0t: result beat with no request pending, tdata %h tuser %0d",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
                    mismatches++;
                end else begin
                    want = pending_grants.pop_front();
                    if (o_m_axis_tdata[12:0] !== want.handle) begin
                        $display("%0t: granted_handle expected %0d, got %0d",
                                 $time, want.handle, o_m_axis_tdata[12:0]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[15:13] !== want.cls) begin
                        $display("%0t: granted_class expected %0d, got %0d",
                                 $time, want.cls, o_m_axis_tdata[15:13]);
                        mismatches++;
                    end
                    if (o_m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (hold_ask) begin
                hold_ask = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        reset_free_lists();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i <= 21; i++) begin
            offer(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        end
        run_phase(LIMIT_RESET, 0, 0, 150, 0, 1'b0, 1'b0, 75);
        run_phase('0, 48, 0, 120, 0, 1'b0, 1'b0, 0);
        run_phase(LIMIT_MAX, 0, 48, 150, 0, 1'b0, 1'b1, 0);
        run_phase(used_kb + KB_W'($urandom_range(200000)), 10, 10, 150, 0, 1'b0, 1'b0, 0);
        // Heavy traffic on the largest class empties its list and moves on to fresh handles.
        run_phase(LIMIT_MAX, 0, 0, 40, 80, 1'b0, 1'b0, 0);
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
